@@ rtl/core/mms_stream_deframer_assert.svh @@
// Assertion macros used by the stream deframer top level.
`ifndef MMS_STREAM_DEFRAMER_ASSERT_SVH
`define MMS_STREAM_DEFRAMER_ASSERT_SVH
// Same-cycle implication, sampled on the rising clock, off during reset.
`define MSD_ASSERT_COMB(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");
// Next-cycle implication, sampled on the rising clock, off during reset.
`define MSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");
`endif

@@ rtl/core/msd_pkg.sv @@
// Types and constants of the stream deframer.
`default_nettype none
package msd_pkg;

   localparam int PosWidth     = 33;
   localparam int LenWidth     = 16;
   localparam int WordBytes    = 4;
   localparam int HdrFirst     = 4;
   localparam int HdrLast      = 11;
   localparam int DataHdrLen   = 8;
   localparam int MsgLenBias   = 16;
   localparam int TypeOffset   = 36;
   localparam int FileIdOffset = 48;
   localparam int MsgMinLen    = 40;
   localparam int OpenMinLen   = 52;
   localparam int CsrAddrWidth = 3;

   localparam logic [31:0] SessionMark     = 32'hb00bface;
   localparam logic [31:0] MsgForFunnel    = 32'h00040001;
   localparam logic [31:0] MsgForOpenFile  = 32'h00040002;
   localparam logic [31:0] MsgForReadBlock = 32'h00040006;
   localparam logic [31:0] MsgNoReplyA     = 32'h00040011;
   localparam logic [31:0] MsgNoReplyB     = 32'h00040005;
   localparam logic [31:0] MsgForStartPlay = 32'h00040021;
   localparam logic [31:0] MsgForPong      = 32'h0004001b;

   localparam logic [7:0] DataKindHeader    = 8'h02;
   localparam logic [7:0] ChunkStreamSwitch = 8'h0c;

   typedef enum logic [0:0] {
      CSR_PACKET_SIZE = 1'b0
   } csr_index_type;

   typedef enum logic [2:0] {
      REPLY_NONE          = 3'd0,
      REPLY_FUNNEL        = 3'd1,
      REPLY_OPEN_FILE     = 3'd2,
      REPLY_READ_BLOCK    = 3'd3,
      REPLY_START_PLAY    = 3'd4,
      REPLY_PONG          = 3'd5,
      REPLY_STREAM_SWITCH = 3'd6
   } reply_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_UNKNOWN_TYPE = 2'd1,
      STATUS_TOO_SHORT    = 2'd2,
      STATUS_OVERSIZE     = 2'd3
   } status_type;

   // One classified byte, handed from the parser to the descriptor stage.
   typedef struct packed {
      logic [7:0]          rx_byte;
      logic                payload_valid;
      logic                frame_end;
      logic                is_data;
      logic [PosWidth-1:0] total;
      logic [7:0]          data_kind;
      logic [7:0]          chunk_kind;
      logic [LenWidth-1:0] data_len;
      logic [31:0]         type_word;
      logic [31:0]         file_id;
   } rec_type;

   typedef struct packed {
      logic [7:0]          payload_byte;
      logic                payload_valid;
      logic                frame_end;
      logic                frame_kind;
      logic [PosWidth-1:0] frame_length;
      logic [7:0]          data_kind;
      logic [7:0]          chunk_kind;
      logic [31:0]         message_code;
      reply_type           reply;
      logic [31:0]         file_id;
      logic [31:0]         pad_count;
      status_type          status;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/msd_front.sv @@
// Byte parser: tracks the frame position, captures header fields, classifies.
`default_nettype none
module msd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_accept,
   input  wire logic [7:0]       in_byte,
   output logic                  push,
   output msd_pkg::rec_type      rec
);
   import msd_pkg::*;

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [PosWidth-1:0] total_ff, total_in;
   logic                is_data_ff, is_data_in;
   logic [31:0]         type_ff, type_in;
   logic [31:0]         fid_ff, fid_in;
   logic [7:0]          hdr_ff  [HdrFirst:HdrLast];
   logic [7:0]          hdr_now [HdrFirst:HdrLast];
   logic [PosWidth-1:0] type_rel, fid_rel;
   logic [LenWidth-1:0] data_len;
   logic [31:0]         mark, msg_len;
   logic                frame_start, at_classify, at_msg_len;
   logic                valid, last;

   always_comb begin
      for (int k = HdrFirst; k <= HdrLast; k++) begin
         hdr_now[k] = (pos_ff == PosWidth'(k)) ? in_byte : hdr_ff[k];
      end
      frame_start = (pos_ff == '0);
      at_classify = (pos_ff == PosWidth'(DataHdrLen - 1));
      at_msg_len  = (pos_ff == PosWidth'(HdrLast));
      mark        = {hdr_now[7], hdr_now[6], hdr_now[5], hdr_now[4]};
      data_len    = {hdr_now[7], hdr_now[6]};
      msg_len     = {hdr_now[11], hdr_now[10], hdr_now[9], hdr_now[8]};

      // classify on the last byte of the common eight-byte header
      if (frame_start) begin
         is_data_in = 1'b0;
      end else if (at_classify) begin
         is_data_in = (mark != SessionMark);
      end else begin
         is_data_in = is_data_ff;
      end

      if (frame_start) begin
         total_in = '0;
      end else if (at_classify && is_data_in) begin
         total_in = (data_len < LenWidth'(DataHdrLen)) ? PosWidth'(DataHdrLen)
                                                       : PosWidth'(data_len);
      end else if (at_msg_len && !is_data_in) begin
         total_in = PosWidth'(msg_len) + PosWidth'(MsgLenBias);
      end else begin
         total_in = total_ff;
      end

      // gather the message type word and the file id, one byte lane at a time
      type_rel = pos_ff - PosWidth'(TypeOffset);
      fid_rel  = pos_ff - PosWidth'(FileIdOffset);
      type_in  = frame_start ? '0 : type_ff;
      fid_in   = frame_start ? '0 : fid_ff;
      if (!is_data_in && type_rel < PosWidth'(WordBytes)) begin
         type_in[{type_rel[1:0], 3'b000} +: 8] = in_byte;
      end
      if (!is_data_in && fid_rel < PosWidth'(WordBytes)) begin
         fid_in[{fid_rel[1:0], 3'b000} +: 8] = in_byte;
      end

      valid = is_data_in && (pos_ff >= PosWidth'(DataHdrLen));
      last  = (pos_ff >= PosWidth'(DataHdrLen - 1)) &&
              (is_data_in || (pos_ff >= PosWidth'(HdrLast))) &&
              (({1'b0, pos_ff} + (PosWidth + 1)'(1)) == {1'b0, total_in});
      pos_in = last ? '0 : pos_ff + PosWidth'(1);

      push               = in_accept && (valid || last);
      rec.rx_byte        = in_byte;
      rec.payload_valid  = valid;
      rec.frame_end      = last;
      rec.is_data        = is_data_in;
      rec.total          = total_in;
      rec.data_kind      = hdr_now[4];
      rec.chunk_kind     = hdr_now[5];
      rec.data_len       = data_len;
      rec.type_word      = type_in;
      rec.file_id        = fid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         is_data_ff <= 1'b0;
      end else if (in_accept) begin
         pos_ff     <= pos_in;
         is_data_ff <= is_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         total_ff <= total_in;
         type_ff  <= type_in;
         fid_ff   <= fid_in;
         for (int k = HdrFirst; k <= HdrLast; k++) begin
            hdr_ff[k] <= hdr_now[k];
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/msd_queue.sv @@
// Short queue of classified bytes between the parser and the descriptor stage.
`default_nettype none
module msd_queue #(
   parameter int Depth = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  msd_pkg::rec_type      push_rec,
   input  wire logic             pop,
   output logic                  head_valid,
   output msd_pkg::rec_type      head,
   output logic                  full
);
   import msd_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   rec_type             q_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                push_ok, pop_ok;

   always_comb begin
      full       = (count_ff == CntWidth'(Depth));
      head_valid = (count_ff != '0);
      head       = q_ff[rd_ptr_ff];
      push_ok    = push && !full;
      pop_ok     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + CntWidth'(1);
         2'b01:   count_in = count_ff - CntWidth'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/msd_back.sv @@
// Descriptor stage: decodes replies, checks sizes, holds the result register.
`default_nettype none
module msd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [31:0]      packet_size,
   input  wire logic             head_valid,
   input  msd_pkg::rec_type      head,
   output logic                  pop,
   input  wire logic             out_stall,
   output logic                  out_valid,
   output msd_pkg::rsp_type      out
);
   import msd_pkg::*;

   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, rsp_in;
   logic [31:0]         open_ff, open_in;
   logic                load;
   logic [LenWidth-1:0] payload_len;
   logic [31:0]         payload_len32;

   always_comb begin
      load          = !out_valid_ff || !out_stall;
      pop           = load && head_valid;
      out_valid_in  = load ? head_valid : out_valid_ff;
      payload_len   = head.data_len - LenWidth'(DataHdrLen);
      payload_len32 = 32'(payload_len);
      open_in       = open_ff;

      rsp_in               = '0;
      rsp_in.payload_byte  = head.payload_valid ? head.rx_byte : 8'h00;
      rsp_in.payload_valid = head.payload_valid;
      rsp_in.frame_end     = head.frame_end;

      if (head.frame_end) begin
         rsp_in.frame_length = head.total;
         if (head.is_data) begin
            rsp_in.frame_kind = 1'b1;
            rsp_in.data_kind  = head.data_kind;
            rsp_in.chunk_kind = head.chunk_kind;
            priority if (head.data_len < LenWidth'(DataHdrLen)) begin
               rsp_in.status = STATUS_TOO_SHORT;
            end else if (head.data_kind == DataKindHeader) begin
               rsp_in.reply = (head.chunk_kind == ChunkStreamSwitch) ? REPLY_STREAM_SWITCH
                                                                     : REPLY_NONE;
            end else if (payload_len32 > packet_size) begin
               rsp_in.status = STATUS_OVERSIZE;
            end else begin
               rsp_in.pad_count = packet_size - payload_len32;
            end
         end else if (head.total < PosWidth'(MsgMinLen)) begin
            rsp_in.status = STATUS_TOO_SHORT;
         end else begin
            rsp_in.message_code = head.type_word;
            unique case (head.type_word)
               MsgForFunnel:    rsp_in.reply = REPLY_FUNNEL;
               MsgForOpenFile:  rsp_in.reply = REPLY_OPEN_FILE;
               MsgForReadBlock: begin
                  if (head.total < PosWidth'(OpenMinLen)) begin
                     rsp_in.status = STATUS_TOO_SHORT;
                  end else begin
                     open_in      = head.file_id;
                     rsp_in.reply = REPLY_READ_BLOCK;
                  end
               end
               MsgNoReplyA:     rsp_in.reply = REPLY_NONE;
               MsgNoReplyB:     rsp_in.reply = REPLY_NONE;
               MsgForStartPlay: rsp_in.reply = REPLY_START_PLAY;
               MsgForPong:      rsp_in.reply = REPLY_PONG;
               default:         rsp_in.status = STATUS_UNKNOWN_TYPE;
            endcase
         end
      end
      rsp_in.file_id = open_in;

      out_valid = out_valid_ff;
      out       = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         open_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            open_ff <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/mms_stream_deframer.sv @@
// Top level of the command and data stream deframer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall  | payload byte plus frame descriptor
//   csr     | in        | APB, pready tied 1   | packet_size at byte address 0
//
// One byte per cycle while the queue has room: the parser updates its position
// counter and its end-of-frame compare for every accepted byte.
// A byte that yields a result is written into the queue when it is accepted;
// the descriptor stage then pops it into the result register, which drives rsp,
// as soon as that register is empty or its result is being taken.
// Synchronous reset clears the position, the queue and the result valid flag;
// no clearing pass, the block takes bytes in the first cycle after reset.
// rsp_stall backs up the queue of QueueDepth entries; req_stall rises when it fills.
`default_nettype none
`include "mms_stream_deframer_assert.svh"
module mms_stream_deframer #(
   parameter int QueueDepth = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // received byte stream
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_rx_byte,
   // parsed results
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_payload_byte,
   output logic                               rsp_payload_valid,
   output logic                               rsp_frame_end,
   output logic                               rsp_frame_kind,
   output logic [msd_pkg::PosWidth-1:0]       rsp_frame_length,
   output logic [7:0]                         rsp_data_kind,
   output logic [7:0]                         rsp_chunk_kind,
   output logic [31:0]                        rsp_message_code,
   output logic [2:0]                         rsp_reply,
   output logic [31:0]                        rsp_file_id,
   output logic [31:0]                        rsp_pad_count,
   output logic [1:0]                         rsp_status,
   // configuration
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [msd_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import msd_pkg::*;

   logic          req_accept;
   logic          push;
   rec_type       push_rec;
   logic          pop;
   logic          head_valid;
   rec_type       head;
   logic          q_full;
   rsp_type       rsp;
   logic [31:0]   packet_size_ff, packet_size_in;
   csr_index_type csr_index;
   logic          csr_write;

   // Take a byte whenever the queue has room; the parser itself never waits.
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   // Register file: one word, word-indexed by the upper address bit.
   always_comb begin
      csr_pready     = 1'b1;
      csr_index      = csr_index_type'(csr_paddr[CsrAddrWidth-1]);
      csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
      packet_size_in = packet_size_ff;
      unique case (csr_index)
         CSR_PACKET_SIZE: begin
            csr_prdata = packet_size_ff;
            if (csr_write) begin
               packet_size_in = csr_pwdata;
            end
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_size_ff <= '0;
      end else begin
         packet_size_ff <= packet_size_in;
      end
   end

   // Front: position tracking, header capture, frame classification.
   msd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_rx_byte),
      .push      (push),
      .rec       (push_rec)
   );

   // Decouple the parser from the result side so each can stall alone.
   msd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .full       (q_full)
   );

   // Back: reply decode, size check, open file id, result register.
   msd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .packet_size (packet_size_ff),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .out_stall   (rsp_stall),
      .out_valid   (rsp_valid),
      .out         (rsp)
   );

   // Split the result register into the channel's field ports.
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_payload_valid = rsp.payload_valid;
   assign rsp_frame_end     = rsp.frame_end;
   assign rsp_frame_kind    = rsp.frame_kind;
   assign rsp_frame_length  = rsp.frame_length;
   assign rsp_data_kind     = rsp.data_kind;
   assign rsp_chunk_kind    = rsp.chunk_kind;
   assign rsp_message_code  = rsp.message_code;
   assign rsp_reply         = rsp.reply;
   assign rsp_file_id       = rsp.file_id;
   assign rsp_pad_count     = rsp.pad_count;
   assign rsp_status        = rsp.status;

   // A result without frame end only exists to carry a payload byte.
   `MSD_ASSERT_COMB(a_result_has_reason, rsp_valid && !rsp_frame_end, rsp_payload_valid)
   // Command messages never forward payload and data packets never carry a type word.
   `MSD_ASSERT_COMB(a_kind_fields, rsp_valid && rsp_frame_end,
                    (rsp_frame_kind || !rsp_payload_valid) &&
                    (!rsp_frame_kind || rsp_message_code == '0))
   // An oversize payload reports no padding.
   `MSD_ASSERT_COMB(a_oversize_no_pad, rsp_valid && rsp_frame_end && rsp_status == STATUS_OVERSIZE,
                    rsp_frame_kind && rsp_pad_count == '0)
   // The queue cannot fill while the result side drains.
   `MSD_ASSERT_NEXT(a_stall_only_when_blocked, !rsp_valid || !rsp_stall, !req_stall)

endmodule
`default_nettype wire

@@ verif/tb_mms_stream_deframer.sv @@
// Self-checking testbench for the command and data stream deframer.
module tb_mms_stream_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import msd_pkg::*;

   // Clock, reset and block ports; every input starts at a known value.
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_rx_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [7:0]              rsp_payload_byte;
   logic                    rsp_payload_valid;
   logic                    rsp_frame_end;
   logic                    rsp_frame_kind;
   logic [PosWidth-1:0]     rsp_frame_length;
   logic [7:0]              rsp_data_kind;
   logic [7:0]              rsp_chunk_kind;
   logic [31:0]             rsp_message_code;
   logic [2:0]              rsp_reply;
   logic [31:0]             rsp_file_id;
   logic [31:0]             rsp_pad_count;
   logic [1:0]              rsp_status;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0]             csr_pwdata = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   mms_stream_deframer uut (.*);

   initial forever #1 clock = ~clock;

   // Hard stop in case the block hangs on a handshake.
   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Stream bytes waiting for the driver, and descriptors still owed by the block.
   logic [7:0] stream_bytes[$];
   logic [7:0] frame_buf[$];
   rsp_type    results_due[$];
   int         mismatches = 0;

   // Handshake flags passed from the rising-edge sampler to the falling-edge drivers.
   bit byte_taken = 1'b0;
   bit result_taken = 1'b0;
   bit send_quiet = 1'b0;
   bit recv_quiet = 1'b0;
   int send_gap = 0;
   int hold_left = 0;

   // Deframer state mirrored by the testbench.
   logic [PosWidth-1:0] stream_pos = '0;
   logic [7:0]          hdr[12] = '{default: 8'h00};
   logic [PosWidth-1:0] span = '0;
   logic                in_data = 1'b0;
   logic [31:0]         msg_type = '0;
   logic [31:0]         pending_id = '0;
   logic [31:0]         open_id = '0;
   logic [31:0]         packet_size_now = '0;

   logic [31:0] known_codes[7] = '{MsgForFunnel, MsgForOpenFile, MsgForReadBlock,
                                   MsgNoReplyA, MsgNoReplyB, MsgForStartPlay, MsgForPong};

   // Advance the mirrored parser by one byte and queue the descriptor it owes, if any.
   task automatic deframe_byte(input logic [7:0] b);
      rsp_type     r;
      logic [15:0] dlen;
      logic [31:0] plen;
      logic        fwd;
      logic        last;
      if (stream_pos == 0) begin
         msg_type   = '0;
         pending_id = '0;
         in_data    = 1'b0;
         span       = '0;
      end
      if (stream_pos < 12) hdr[stream_pos[3:0]] = b;
      dlen = {hdr[7], hdr[6]};
      // Classify once the session mark word is complete.
      if (stream_pos == 7) begin
         if ({hdr[7], hdr[6], hdr[5], hdr[4]} == SessionMark) begin
            in_data = 1'b0;
         end else begin
            in_data = 1'b1;
            span    = (dlen < DataHdrLen) ? PosWidth'(DataHdrLen) : PosWidth'(dlen);
         end
      end
      if (stream_pos == 11 && !in_data)
         span = PosWidth'({hdr[11], hdr[10], hdr[9], hdr[8]}) + MsgLenBias;
      // Gather the type word and the file id of a message.
      if (!in_data) begin
         if (stream_pos >= TypeOffset && stream_pos < TypeOffset + WordBytes)
            msg_type |= 32'(b) << (8 * int'(stream_pos - TypeOffset));
         if (stream_pos >= FileIdOffset && stream_pos < FileIdOffset + WordBytes)
            pending_id |= 32'(b) << (8 * int'(stream_pos - FileIdOffset));
      end
      fwd  = in_data && stream_pos >= DataHdrLen;
      last = stream_pos >= 7 && (in_data || stream_pos >= HdrLast) && stream_pos + 1 == span;

      r = '0;
      r.payload_byte  = fwd ? b : 8'h00;
      r.payload_valid = fwd;
      r.frame_end     = last;
      r.reply         = REPLY_NONE;
      r.status        = STATUS_OK;
      if (last) begin
         r.frame_kind   = in_data;
         r.frame_length = span;
         if (in_data) begin
            r.data_kind  = hdr[4];
            r.chunk_kind = hdr[5];
            if (dlen < DataHdrLen) begin
               r.status = STATUS_TOO_SHORT;
            end else if (hdr[4] == DataKindHeader) begin
               // Header packets skip the size check.
               r.reply = (hdr[5] == ChunkStreamSwitch) ? REPLY_STREAM_SWITCH : REPLY_NONE;
            end else begin
               plen = 32'(dlen) - DataHdrLen;
               if (plen > packet_size_now) r.status = STATUS_OVERSIZE;
               else r.pad_count = packet_size_now - plen;
            end
         end else if (span < MsgMinLen) begin
            r.status = STATUS_TOO_SHORT;
         end else begin
            r.message_code = msg_type;
            case (msg_type)
               MsgForFunnel:    r.reply = REPLY_FUNNEL;
               MsgForOpenFile:  r.reply = REPLY_OPEN_FILE;
               MsgForReadBlock: begin
                  // Keep the old file id when the frame cannot hold a new one.
                  if (span < OpenMinLen) begin
                     r.status = STATUS_TOO_SHORT;
                  end else begin
                     open_id = pending_id;
                     r.reply = REPLY_READ_BLOCK;
                  end
               end
               MsgNoReplyA, MsgNoReplyB: ;
               MsgForStartPlay: r.reply = REPLY_START_PLAY;
               MsgForPong:      r.reply = REPLY_PONG;
               default:         r.status = STATUS_UNKNOWN_TYPE;
            endcase
         end
         stream_pos = '0;
      end else begin
         stream_pos = stream_pos + 1;
      end
      r.file_id = open_id;
      if (fwd || last) results_due.push_back(r);
   endtask

   task automatic note_field(input string what, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         if (mismatches < 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // Match one result transaction against the oldest owed descriptor.
   task automatic compare_result();
      rsp_type want;
      if (results_due.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: result with nothing owed, payload %0h frame_end %0b",
                     $time, rsp_payload_byte, rsp_frame_end);
         mismatches++;
      end else begin
         want = results_due.pop_front();
         note_field("payload_byte", want.payload_byte, rsp_payload_byte);
         note_field("payload_valid", want.payload_valid, rsp_payload_valid);
         note_field("frame_end", want.frame_end, rsp_frame_end);
         note_field("frame_kind", want.frame_kind, rsp_frame_kind);
         note_field("frame_length", want.frame_length, rsp_frame_length);
         note_field("data_kind", want.data_kind, rsp_data_kind);
         note_field("chunk_kind", want.chunk_kind, rsp_chunk_kind);
         note_field("message_code", want.message_code, rsp_message_code);
         note_field("reply", want.reply, rsp_reply);
         note_field("file_id", want.file_id, rsp_file_id);
         note_field("pad_count", want.pad_count, rsp_pad_count);
         note_field("status", want.status, rsp_status);
      end
   endtask

   // Sample both channels at the rising edge; check before predicting so a new
   // byte can never satisfy a result of the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            compare_result();
            result_taken = 1'b1;
         end
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
            byte_taken = 1'b1;
         end
      end
   end

   // Byte driver: hold a stalled transaction, then wait a drawn gap before the next.
   always @(negedge clock) begin : byte_driver
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (byte_taken) begin
            byte_taken = 1'b0;
            next_valid = 1'b0;
            if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
            send_gap = send_quiet ? 0 : $urandom_range(0, 19);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (stream_bytes.size() > 0) begin
               req_rx_byte <= stream_bytes.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   // Result side: stall for a drawn number of cycles after each accepted transaction.
   always @(negedge clock) begin
      if (result_taken) begin
         result_taken = 1'b0;
         if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
         hold_left = recv_quiet ? 0 : $urandom_range(0, 19);
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Block until every byte is taken and every owed result has come back.
   task automatic wait_idle();
      do @(posedge clock);
      while (stream_bytes.size() != 0 || req_valid || results_due.size() != 0);
   endtask

   // Write packet_size over APB while the block is idle, then read it back.
   task automatic program_packet_size(input logic [31:0] value);
      wait_idle();
      // Let any byte without a result drain out of the pipe.
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CsrAddrWidth'(4 * CSR_PACKET_SIZE);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      packet_size_now = value;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      note_field("packet_size readback", value, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Frame builders fill frame_buf; ship_frame hands it to the driver.
   task automatic build_data(input logic [7:0] kind, input logic [7:0] chunk,
                             input logic [15:0] len);
      int n;
      frame_buf.delete();
      n = (len < DataHdrLen) ? DataHdrLen : int'(len);
      repeat (HdrFirst) frame_buf.push_back(8'($urandom));
      frame_buf.push_back(kind);
      frame_buf.push_back(chunk);
      frame_buf.push_back(len[7:0]);
      frame_buf.push_back(len[15:8]);
      for (int i = DataHdrLen; i < n; i++) frame_buf.push_back(8'($urandom));
   endtask

   task automatic build_message(input logic [31:0] body_len, input logic [31:0] code,
                                input logic [31:0] fid);
      logic [7:0] v;
      frame_buf.delete();
      for (int i = 0; i < int'(body_len) + MsgLenBias; i++) begin
         v = 8'($urandom);
         if (i >= HdrFirst && i < HdrFirst + WordBytes)
            v = SessionMark[8 * (i - HdrFirst) +: 8];
         else if (i >= DataHdrLen && i <= HdrLast)
            v = body_len[8 * (i - DataHdrLen) +: 8];
         else if (i >= TypeOffset && i < TypeOffset + WordBytes)
            v = code[8 * (i - TypeOffset) +: 8];
         else if (i >= FileIdOffset && i < FileIdOffset + WordBytes)
            v = fid[8 * (i - FileIdOffset) +: 8];
         frame_buf.push_back(v);
      end
   endtask

   // Hand a frame to the driver; with a cut, pause there until the block drains.
   task automatic ship_frame(input int cut);
      for (int i = 0; i < frame_buf.size(); i++) begin
         if (cut > 0 && i == cut) wait_idle();
         stream_bytes.push_back(frame_buf[i]);
      end
   endtask

   // One random frame: mostly well-formed frames, some short ones as noise.
   task automatic random_frame(output int n);
      int          pick;
      logic [31:0] code;
      logic [7:0]  kind;
      pick = $urandom_range(0, 99);
      code = ($urandom_range(0, 7) == 7) ? $urandom : known_codes[$urandom_range(0, 6)];
      if (pick < 45) begin
         build_message($urandom_range(OpenMinLen - MsgLenBias, 50), code, $urandom);
      end else if (pick < 80) begin
         kind = ($urandom_range(0, 3) == 0) ? DataKindHeader : 8'($urandom);
         build_data(kind, ($urandom_range(0, 1) == 0) ? ChunkStreamSwitch : 8'($urandom),
                    16'($urandom_range(DataHdrLen, DataHdrLen + 40)));
      end else if (pick < 90) begin
         build_message($urandom_range(0, OpenMinLen - MsgLenBias - 1), code, $urandom);
      end else begin
         build_data(8'($urandom), 8'($urandom), 16'($urandom_range(0, DataHdrLen - 1)));
      end
      n = frame_buf.size();
      ship_frame(0);
   endtask

   initial begin
      logic [31:0] phase_size[5];
      int          phase_bytes;
      int          n;

      // Hold reset, then release it on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames, with a small packet size so pads and overflow both show.
      program_packet_size(32'd16);
      build_data(8'h01, 8'h00, 16'd0);                 ship_frame(0);
      build_data(8'hff, 8'hff, 16'd7);                 ship_frame(0);
      build_data(8'h01, 8'h00, 16'd8);                 ship_frame(0);
      build_data(8'h01, 8'h33, 16'd24);                ship_frame(0);
      build_data(8'h80, 8'h00, 16'd20);                ship_frame(0);
      // Oversize payload; pause the sender in the middle of it.
      build_data(8'h01, 8'h00, 16'd25);                ship_frame(12);
      build_data(DataKindHeader, ChunkStreamSwitch, 16'd12); ship_frame(0);
      build_data(DataKindHeader, 8'h01, 16'd30);       ship_frame(0);
      build_data(DataKindHeader, ChunkStreamSwitch, 16'd5);  ship_frame(0);
      // Only the read-block message needs room for a file id.
      foreach (known_codes[i]) begin
         build_message((known_codes[i] == MsgForReadBlock) ? 32'd36 : 32'd24,
                       known_codes[i], $urandom);
         ship_frame(0);
      end
      build_message(32'd24, 32'hffff_ffff, 32'h0);     ship_frame(0);
      build_message(32'd0, MsgForFunnel, 32'h0);       ship_frame(0);
      build_message(32'd23, MsgForFunnel, 32'h0);      ship_frame(0);
      build_message(32'd24, MsgForPong, 32'h0);        ship_frame(0);
      // Read-block message one byte too short to carry a file id.
      build_message(32'd35, MsgForReadBlock, $urandom); ship_frame(0);

      // Random phases, each under its own packet size, extremes included.
      phase_size = '{32'd0, 32'hffff_ffff, 32'($urandom_range(0, 48)),
                     32'($urandom_range(0, 48)), $urandom};
      foreach (phase_size[p]) begin
         program_packet_size(phase_size[p]);
         phase_bytes = 0;
         while (phase_bytes < 24) begin
            random_frame(n);
            phase_bytes += n;
         end
      end

      // Drain, then allow for the pipe latency before judging the run.
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && results_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/msd_pkg.sv
rtl/core/msd_front.sv
rtl/core/msd_queue.sv
rtl/core/msd_back.sv
rtl/core/mms_stream_deframer.sv
verif/tb_mms_stream_deframer.sv
